[hw/rtl/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants for the projector strain derivative block: default
// number format, register map and axis codes.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 20;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SCALE_W   = 31;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1048576);

  localparam logic [CFG_IDX_W-1:0] REG_KVEC_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KVEC_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KVEC_Z        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_AXIS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_AXIS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SCALE = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

[hw/rtl/projector_strain_derivative.sv]
// ----------------------------------------------------------------------------
// projector_strain_derivative
// Streams plane-wave elements: forms q = G + k, updates the complex
// accumulator and the complex strain derivative, saturating per component.
// Takes one request per clock while the output is not stalled and returns
// one result per request, in order. The length is set by the square root of
// |q|^2, one root bit per stage, and the division by |q|, one quotient bit per
// stage; every stage is registered and the whole pipeline holds when the
// output is stalled.
// ----------------------------------------------------------------------------
module projector_strain_derivative
  import psd_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_gvec_x,
  input  logic [31:0]          in_gvec_y,
  input  logic [31:0]          in_gvec_z,
  input  logic [63:0]          in_proj_i,
  input  logic [63:0]          in_proj_j,
  input  logic [63:0]          in_proj_base,
  input  logic [63:0]          in_acc_in,
  input  logic [63:0]          in_proj_radial,
  input  logic [63:0]          in_deriv_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_acc_out,
  output logic [63:0]          out_deriv_out,
  output logic                 out_saturated
);

  localparam int DW = DATA_WIDTH;
  localparam int W2 = 2 * DW;
  localparam int WW = 2 * DW + 32;
  localparam int PW = DW + SCALE_W;

  localparam logic signed [WW-1:0] MAXV = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [WW-1:0] MINV = ~MAXV;

  typedef struct packed {
    logic [DW-1:0] vi;
    logic [DW-1:0] vj;
    logic [DW-1:0] vb;
    logic [DW-1:0] a1;
    logic [DW-1:0] v2;
    logic [DW-1:0] dn;
  } cmp_t;

  typedef struct packed {
    logic                sat;
    logic                neg;
    logic                zero;
    logic [W2-1:0]       p;
    logic [1:0][WW-1:0]  t;
    logic [1:0][DW-1:0]  v2;
    logic [1:0][DW-1:0]  acc;
  } tail_t;

  typedef struct packed {
    tail_t         tl;
    logic [DW+1:0] rem;
    logic [DW-1:0] root;
    logic [W2-1:0] nn;
  } sq_t;

  typedef struct packed {
    tail_t         tl;
    logic [DW-1:0] r;
    logic [DW-1:0] rem;
    logic [W2-1:0] nq;
  } dv_t;

  function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] x);
    return x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  function automatic logic signed [WW-1:0] ext_f(input logic signed [DW-1:0] x);
    return WW'(x);
  endfunction

  function automatic logic ovf_f(input logic signed [WW-1:0] x);
    return (x > MAXV) || (x < MINV);
  endfunction

  function automatic logic signed [DW-1:0] clip_f(input logic signed [WW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > MAXV) r = MAXV[DW-1:0];
    else if (x < MINV) r = MINV[DW-1:0];
    else r = x[DW-1:0];
    return r;
  endfunction

  function automatic logic signed [WW-1:0] rnd_f(input logic [WW-1:0] pm, input logic neg);
    logic [WW-1:0] r;
    r = (pm + (WW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [WW-1:0] half_f(input logic signed [WW-1:0] s);
    logic [WW-1:0] m;
    m = s[WW-1] ? WW'(-s) : WW'(s);
    m = (m + WW'(1)) >> 1;
    return s[WW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [DW-1:0] sel_f(input logic [1:0] ax,
                                                 input logic signed [DW-1:0] qx,
                                                 input logic signed [DW-1:0] qy,
                                                 input logic signed [DW-1:0] qz);
    logic signed [DW-1:0] r;
    case (ax)
      AXIS_X:  r = qx;
      AXIS_Y:  r = qy;
      AXIS_Z:  r = qz;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic sq_t sq_step(input sq_t x);
    sq_t           y;
    logic [DW+3:0] rr;
    logic [DW+3:0] tr;
    y    = x;
    rr   = {x.rem, x.nn[W2-1:W2-2]};
    tr   = (DW+4)'({x.root, 2'b01});
    y.nn = x.nn << 2;
    if (rr >= tr) begin
      y.rem  = (DW+2)'(rr - tr);
      y.root = {x.root[DW-2:0], 1'b1};
    end else begin
      y.rem  = rr[DW+1:0];
      y.root = {x.root[DW-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic dv_t dv_step(input dv_t x);
    dv_t         y;
    logic [DW:0] rr;
    logic        b;
    y  = x;
    rr = {x.rem, x.nq[W2-1]};
    b  = (rr >= {1'b0, x.r});
    y.rem = b ? DW'(rr - {1'b0, x.r}) : rr[DW-1:0];
    y.nq  = {x.nq[W2-2:0], b};
    return y;
  endfunction

  // configuration
  logic signed [DW-1:0] kx_r, ky_r, kz_r;
  logic [1:0]           axis_i_r, axis_j_r;
  logic [SCALE_W-1:0]   scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kx_r     <= '0;
      ky_r     <= '0;
      kz_r     <= '0;
      axis_i_r <= '0;
      axis_j_r <= '0;
      scale_r  <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KVEC_X:        kx_r     <= cfg_wdata[DW-1:0];
        REG_KVEC_Y:        ky_r     <= cfg_wdata[DW-1:0];
        REG_KVEC_Z:        kz_r     <= cfg_wdata[DW-1:0];
        REG_FIRST_AXIS:    axis_i_r <= cfg_wdata[1:0];
        REG_SECOND_AXIS:   axis_j_r <= cfg_wdata[1:0];
        REG_LATTICE_SCALE: scale_r  <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage 1: q = G + k
  logic signed [WW-1:0] qs_x, qs_y, qs_z;
  logic signed [DW-1:0] qc_x, qc_y, qc_z;
  cmp_t                 cm_c [2];

  always_comb begin
    qs_x = ext_f(in_gvec_x[DW-1:0]) + ext_f(kx_r);
    qs_y = ext_f(in_gvec_y[DW-1:0]) + ext_f(ky_r);
    qs_z = ext_f(in_gvec_z[DW-1:0]) + ext_f(kz_r);
    qc_x = clip_f(qs_x);
    qc_y = clip_f(qs_y);
    qc_z = clip_f(qs_z);
    cm_c[0] = '{vi: in_proj_i[32 +: DW], vj: in_proj_j[32 +: DW],
                vb: in_proj_base[32 +: DW], a1: in_acc_in[32 +: DW],
                v2: in_proj_radial[32 +: DW], dn: in_deriv_in[32 +: DW]};
    cm_c[1] = '{vi: in_proj_i[0 +: DW], vj: in_proj_j[0 +: DW],
                vb: in_proj_base[0 +: DW], a1: in_acc_in[0 +: DW],
                v2: in_proj_radial[0 +: DW], dn: in_deriv_in[0 +: DW]};
  end

  logic                 vld1_r;
  logic signed [DW-1:0] q1_r [3];
  logic signed [DW-1:0] qi1_r, qj1_r;
  logic                 sat1_r, eq1_r;
  cmp_t                 cm1_r [2];

  // stage 2: products
  logic                 vld2_r;
  logic [W2-1:0]        sq2_r [3];
  logic [W2-1:0]        p2_r;
  logic                 neg2_r;
  logic [W2-1:0]        pa2_r [2], pb2_r [2];
  logic                 na2_r [2], nb2_r [2];
  logic                 sat2_r, eq2_r;
  cmp_t                 cm2_r [2];

  // stage 3: |q|^2 and the rounded projector sum
  logic                 vld3_r;
  logic [W2-1:0]        n23_r, p3_r;
  logic                 neg3_r, sat3_r, eq3_r;
  logic signed [WW-1:0] s3_r [2];
  cmp_t                 cm3_r [2];

  // accumulator update, square root entry
  sq_t                  sq_c0;
  always_comb begin
    logic signed [DW-1:0] a;
    logic                 sat;
    sat = sat3_r;
    sq_c0 = '0;
    for (int c = 0; c < 2; c++) begin
      logic signed [WW-1:0] aw;
      aw = ext_f(cm3_r[c].a1) + half_f(s3_r[c]);
      a  = clip_f(aw);
      sat = sat | ovf_f(aw);
      sq_c0.tl.acc[c] = a;
      sq_c0.tl.v2[c]  = cm3_r[c].v2;
      sq_c0.tl.t[c]   = ext_f(cm3_r[c].dn) - (ext_f(a) <<< 1)
                        - (eq3_r ? ext_f(cm3_r[c].vb) : '0);
    end
    sq_c0.tl.sat  = sat;
    sq_c0.tl.neg  = neg3_r;
    sq_c0.tl.zero = (n23_r == '0);
    sq_c0.tl.p    = p3_r;
    sq_c0.nn      = n23_r;
  end

  sq_t          sq_r  [DW+1];
  sq_t          sq_n  [DW+1];
  logic [DW:0]  sq_v_r;
  dv_t          dv_r  [W2+1];
  dv_t          dv_n  [W2+1];
  logic [W2:0]  dv_v_r;

  always_comb begin
    sq_n[0] = sq_c0;
    for (int k = 0; k < DW; k++) sq_n[k+1] = sq_step(sq_r[k]);
    dv_n[0].tl  = sq_r[DW].tl;
    dv_n[0].r   = sq_r[DW].root;
    dv_n[0].rem = '0;
    dv_n[0].nq  = sq_r[DW].tl.p + W2'(sq_r[DW].root >> 1);
    for (int k = 0; k < W2; k++) dv_n[k+1] = dv_step(dv_r[k]);
  end

  // w = q_i q_j / |q|
  logic signed [WW-1:0] wx;
  logic signed [DW-1:0] w_c;
  logic                 wsat_c;
  tail_t                tw_c;
  always_comb begin
    wx     = dv_r[W2].tl.neg ? -$signed(WW'(dv_r[W2].nq)) : $signed(WW'(dv_r[W2].nq));
    w_c    = dv_r[W2].tl.zero ? '0 : clip_f(wx);
    wsat_c = !dv_r[W2].tl.zero && ovf_f(wx);
    tw_c     = dv_r[W2].tl;
    tw_c.sat = dv_r[W2].tl.sat | wsat_c;
  end

  logic                 vw_r, vmp_r, vm_r, vvp_r;
  logic signed [DW-1:0] w_r, m_r;
  tail_t                tw_r, tmp_r, tm_r, tvp_r;
  logic [PW-1:0]        pm_r;
  logic                 negm_r;
  logic [W2-1:0]        pv_r [2];
  logic                 nv_r [2];

  logic signed [WW-1:0] mx;
  assign mx = rnd_f(WW'(pm_r), negm_r);

  tail_t                tm_c;
  always_comb begin
    tm_c     = tmp_r;
    tm_c.sat = tmp_r.sat | ovf_f(mx);
  end

  logic [63:0]          acc_o_c, der_o_c;
  logic                 osat_c;
  always_comb begin
    logic signed [WW-1:0] dx;
    logic signed [DW-1:0] d [2];
    osat_c = tvp_r.sat;
    for (int c = 0; c < 2; c++) begin
      dx     = $signed(tvp_r.t[c]) - (rnd_f(WW'(pv_r[c]), nv_r[c]) <<< 1);
      d[c]   = clip_f(dx);
      osat_c = osat_c | ovf_f(dx);
    end
    der_o_c = {32'($signed(d[0])), 32'($signed(d[1]))};
    acc_o_c = {32'($signed(tvp_r.acc[0])), 32'($signed(tvp_r.acc[1]))};
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      sq_v_r      <= '0;
      dv_v_r      <= '0;
      vw_r        <= 1'b0;
      vmp_r       <= 1'b0;
      vm_r        <= 1'b0;
      vvp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld1_r      <= in_valid;
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      sq_v_r      <= {sq_v_r[DW-1:0], vld3_r};
      dv_v_r      <= {dv_v_r[W2-1:0], sq_v_r[DW]};
      vw_r        <= dv_v_r[W2];
      vmp_r       <= vw_r;
      vm_r        <= vmp_r;
      vvp_r       <= vm_r;
      out_valid_r <= vvp_r;
    end
  end

  // data path
  logic [63:0] acc_out_r, deriv_out_r;
  logic        sat_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_r[0] <= qc_x;
      q1_r[1] <= qc_y;
      q1_r[2] <= qc_z;
      qi1_r   <= sel_f(axis_i_r, qc_x, qc_y, qc_z);
      qj1_r   <= sel_f(axis_j_r, qc_x, qc_y, qc_z);
      sat1_r  <= ovf_f(qs_x) | ovf_f(qs_y) | ovf_f(qs_z);
      eq1_r   <= (axis_i_r == axis_j_r);
      cm1_r   <= cm_c;

      for (int a = 0; a < 3; a++)
        sq2_r[a] <= W2'(mag_f(q1_r[a])) * W2'(mag_f(q1_r[a]));
      p2_r   <= W2'(mag_f(qi1_r)) * W2'(mag_f(qj1_r));
      neg2_r <= qi1_r[DW-1] ^ qj1_r[DW-1];
      for (int c = 0; c < 2; c++) begin
        pa2_r[c] <= W2'(mag_f(qi1_r)) * W2'(mag_f(cm1_r[c].vj));
        na2_r[c] <= qi1_r[DW-1] ^ cm1_r[c].vj[DW-1];
        pb2_r[c] <= W2'(mag_f(qj1_r)) * W2'(mag_f(cm1_r[c].vi));
        nb2_r[c] <= qj1_r[DW-1] ^ cm1_r[c].vi[DW-1];
      end
      sat2_r <= sat1_r;
      eq2_r  <= eq1_r;
      cm2_r  <= cm1_r;

      n23_r  <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      p3_r   <= p2_r;
      neg3_r <= neg2_r;
      for (int c = 0; c < 2; c++)
        s3_r[c] <= rnd_f(WW'(pa2_r[c]), na2_r[c]) + rnd_f(WW'(pb2_r[c]), nb2_r[c]);
      sat3_r <= sat2_r;
      eq3_r  <= eq2_r;
      cm3_r  <= cm2_r;

      sq_r <= sq_n;
      dv_r <= dv_n;

      w_r    <= w_c;
      tw_r   <= tw_c;

      pm_r   <= PW'(mag_f(w_r)) * PW'(scale_r);
      negm_r <= w_r[DW-1];
      tmp_r  <= tw_r;

      m_r    <= clip_f(mx);
      tm_r   <= tm_c;

      for (int c = 0; c < 2; c++) begin
        pv_r[c] <= W2'(mag_f(tm_r.v2[c])) * W2'(mag_f(m_r));
        nv_r[c] <= tm_r.v2[c][DW-1] ^ m_r[DW-1];
      end
      tvp_r <= tm_r;

      acc_out_r   <= acc_o_c;
      deriv_out_r <= der_o_c;
      sat_out_r   <= osat_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_acc_out   = acc_out_r;
  assign out_deriv_out = deriv_out_r;
  assign out_saturated = sat_out_r;

endmodule

[hw/rtl/psd_checker.sv]
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the projector strain derivative block.
// ----------------------------------------------------------------------------
module psd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_acc_out,
  input logic [63:0] out_deriv_out,
  input logic        out_saturated
);

  // nothing leaves the block straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a request is taken exactly when the output stage can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready not tied to output progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_acc_out)
      && $stable(out_deriv_out) && $stable(out_saturated))
    else $error("stalled result changed");

endmodule

bind projector_strain_derivative psd_checker u_psd_checker (.*);
